[hw/rtl/ata_pio_transfer_sequencer_top_macros.svh]
// ----------------------------------------------------------------------------
// ATA PIO sequencer assertion macros
// Concurrent assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ATA_PIO_TRANSFER_SEQUENCER_TOP_MACROS_SVH
`define ATA_PIO_TRANSFER_SEQUENCER_TOP_MACROS_SVH

// Assertion sampled on clk and switched off while reset is applied.
`define ATA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion sampled on clk that also holds across reset.
`define ATA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/ata_seq_pkg.sv]
// ----------------------------------------------------------------------------
// ATA PIO sequencer package
// Shared constants, codes and structures of the LBA28 transfer sequencer.
// ----------------------------------------------------------------------------
package ata_seq_pkg;

  localparam int CHUNK_SECTORS    = 255;
  localparam int WORDS_PER_SECTOR = 256;

  localparam int RETRY_W = 20;
  localparam int WAIT_W  = 16;
  localparam int LBA_W   = 28;

  localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 20'd1000000;
  localparam logic [WAIT_W-1:0]  SPINUP_WAIT_RST = 16'd1000;

  // Request types on the input channel.
  localparam logic [1:0] REQ_START  = 2'd0;
  localparam logic [1:0] REQ_STATUS = 2'd1;
  localparam logic [1:0] REQ_DATA   = 2'd2;

  // Result actions.
  localparam logic [2:0] ACT_REG_WRITE = 3'd0;
  localparam logic [2:0] ACT_POLL      = 3'd1;
  localparam logic [2:0] ACT_TO_DRIVE  = 3'd2;
  localparam logic [2:0] ACT_TO_HOST   = 3'd3;
  localparam logic [2:0] ACT_WAIT      = 3'd4;
  localparam logic [2:0] ACT_DPHASE    = 3'd5;
  localparam logic [2:0] ACT_DONE      = 3'd6;

  // Task file register offsets.
  localparam logic [2:0] TF_COUNT   = 3'd2;
  localparam logic [2:0] TF_LBA_LO  = 3'd3;
  localparam logic [2:0] TF_LBA_MID = 3'd4;
  localparam logic [2:0] TF_LBA_HI  = 3'd5;
  localparam logic [2:0] TF_DRVHEAD = 3'd6;
  localparam logic [2:0] TF_COMMAND = 3'd7;

  // Command and drive/head bytes.
  localparam logic [7:0] CMD_READ     = 8'h20;
  localparam logic [7:0] CMD_WRITE    = 8'h30;
  localparam logic [7:0] CMD_FLUSH    = 8'hE7;
  localparam logic [3:0] DRVHEAD_BASE = 4'b1110;

  // Status register bits.
  localparam int ST_BSY = 7;
  localparam int ST_RDY = 6;
  localparam int ST_DRQ = 3;

  // Configuration register indexes.
  localparam logic CFG_RETRY_LIMIT = 1'b0;
  localparam logic CFG_SPINUP_WAIT = 1'b1;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_POLL  = 5'b00010,
    PH_DATA  = 5'b00100,
    PH_FLUSH = 5'b01000,
    PH_GAP   = 5'b10000
  } phase_t;

  // Kinds of result bursts that one input item can cause.
  typedef enum logic [3:0] {
    BK_DONE       = 4'd0,
    BK_CHUNK      = 4'd1,
    BK_DPHASE     = 4'd2,
    BK_WAITPOLL   = 4'd3,
    BK_POLL       = 4'd4,
    BK_WORD       = 4'd5,
    BK_WORDPOLL   = 4'd6,
    BK_WORDFLUSH  = 4'd7,
    BK_WORDDONE   = 4'd8
  } burst_kind_t;

  typedef struct packed {
    burst_kind_t        kind;
    logic               writing;
    logic [LBA_W-1:0]   lba;
    logic [7:0]         count;
    logic [15:0]        data;
    logic [WAIT_W-1:0]  wait_ms;
    logic               ok;
  } burst_t;

  typedef struct packed {
    logic [RETRY_W-1:0] retry_limit;
    logic [WAIT_W-1:0]  spinup_wait_ms;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [2:0]        reg_index;
    logic [7:0]        reg_value;
    logic [15:0]       data_out;
    logic [WAIT_W-1:0] wait_ms;
    logic              success;
    logic              last;
  } result_t;

endpackage

[hw/rtl/ata_seq_regs.sv]
// ----------------------------------------------------------------------------
// ATA PIO sequencer configuration registers
// APB-style register file holding the retry limit and spin-up wait.
// ----------------------------------------------------------------------------
module ata_seq_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output ata_seq_pkg::cfg_t   cfg
);
  import ata_seq_pkg::*;

  logic [RETRY_W-1:0] retry_limit_r;
  logic [WAIT_W-1:0]  spinup_wait_r;
  logic               wr_en;

  // The byte offset within a word is ignored.
  assign wr_en = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= RETRY_LIMIT_RST;
      spinup_wait_r <= SPINUP_WAIT_RST;
    end else if (wr_en) begin
      if (paddr[2] == CFG_RETRY_LIMIT) begin
        retry_limit_r <= pwdata[RETRY_W-1:0];
      end else begin
        spinup_wait_r <= pwdata[WAIT_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == CFG_SPINUP_WAIT) begin
      prdata = {{(32-WAIT_W){1'b0}}, spinup_wait_r};
    end else begin
      prdata = {{(32-RETRY_W){1'b0}}, retry_limit_r};
    end
  end

  assign cfg.retry_limit    = retry_limit_r;
  assign cfg.spinup_wait_ms = spinup_wait_r;

endmodule

[hw/rtl/ata_seq_core.sv]
// ----------------------------------------------------------------------------
// ATA PIO sequencer decision core
// Holds the transfer state and turns one accepted item into a result burst.
// ----------------------------------------------------------------------------
module ata_seq_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic [1:0]          req_type,
  input  logic                write_op,
  input  logic [31:0]         start_lba,
  input  logic [31:0]         sector_total,
  input  logic [7:0]          status_byte,
  input  logic [15:0]         data_in,
  input  ata_seq_pkg::cfg_t   cfg,
  output logic                load,
  output ata_seq_pkg::burst_t burst
);
  import ata_seq_pkg::*;

  phase_t             phase_r, phase_nxt;
  logic               writing_r, writing_nxt;
  logic [31:0]        sectors_r, sectors_nxt;
  logic [LBA_W-1:0]   lba_r, lba_nxt;
  logic [7:0]         chunk_r, chunk_nxt;
  logic [8:0]         word_r, word_nxt;
  logic [RETRY_W-1:0] retries_r, retries_nxt;

  logic               is_start;
  logic               src_writing;
  logic [31:0]        src_sectors;
  logic [LBA_W-1:0]   src_lba;
  logic [7:0]         chunk_size;
  logic [RETRY_W-1:0] retries_dec;
  logic [8:0]         word_inc;
  logic               word_wrap;
  logic [31:0]        sectors_dec;
  logic [7:0]         chunk_dec;
  logic               st_bsy, st_rdy, st_drq;
  logic               go_data, spin;

  // A chunk issued by a start item uses the new job, otherwise the stored one.
  assign is_start    = (req_type == REQ_START);
  assign src_writing = is_start ? write_op : writing_r;
  assign src_sectors = is_start ? sector_total : sectors_r;
  assign src_lba     = is_start ? start_lba[LBA_W-1:0] : lba_r;
  assign chunk_size  = (src_sectors < 32'(CHUNK_SECTORS)) ? src_sectors[7:0]
                                                          : 8'(CHUNK_SECTORS);

  assign retries_dec = retries_r - 1'b1;
  assign word_inc    = word_r + 1'b1;
  assign word_wrap   = (word_inc >= 9'(WORDS_PER_SECTOR));
  assign sectors_dec = sectors_r - 1'b1;
  assign chunk_dec   = chunk_r - 1'b1;

  assign st_bsy = status_byte[ST_BSY];
  assign st_rdy = status_byte[ST_RDY];
  assign st_drq = status_byte[ST_DRQ];

  // On a write, DRQ wins over everything; otherwise BSY, then RDY, then DRQ.
  assign go_data = (writing_r & st_drq) | (~st_bsy & st_rdy & st_drq);
  assign spin    = ~(writing_r & st_drq) & ~st_bsy & ~st_rdy;

  always_comb begin
    phase_nxt     = phase_r;
    writing_nxt   = writing_r;
    sectors_nxt   = sectors_r;
    lba_nxt       = lba_r;
    chunk_nxt     = chunk_r;
    word_nxt      = word_r;
    retries_nxt   = retries_r;
    load          = 1'b0;
    burst.kind    = BK_POLL;
    burst.writing = src_writing;
    burst.lba     = src_lba;
    burst.count   = chunk_size;
    burst.data    = data_in;
    burst.wait_ms = cfg.spinup_wait_ms;
    burst.ok      = 1'b1;

    if (accept) begin
      unique case (req_type)
        REQ_START: begin
          writing_nxt = write_op;
          lba_nxt     = start_lba[LBA_W-1:0];
          sectors_nxt = sector_total;
          load        = 1'b1;
          if (sector_total == 32'd0) begin
            chunk_nxt  = '0;
            word_nxt   = '0;
            retries_nxt = '0;
            phase_nxt  = PH_IDLE;
            burst.kind = BK_DONE;
          end else begin
            chunk_nxt   = chunk_size;
            word_nxt    = '0;
            retries_nxt = cfg.retry_limit;
            phase_nxt   = PH_POLL;
            burst.kind  = BK_CHUNK;
          end
        end
        REQ_STATUS: begin
          unique case (phase_r)
            PH_POLL: begin
              load = 1'b1;
              if (retries_r == '0) begin
                phase_nxt  = PH_IDLE;
                burst.kind = BK_DONE;
                burst.ok   = 1'b0;
              end else if (go_data) begin
                word_nxt   = '0;
                phase_nxt  = PH_DATA;
                burst.kind = BK_DPHASE;
              end else begin
                retries_nxt = retries_dec;
                if (retries_dec == '0) begin
                  phase_nxt  = PH_IDLE;
                  burst.kind = BK_DONE;
                  burst.ok   = 1'b0;
                end else begin
                  burst.kind = spin ? BK_WAITPOLL : BK_POLL;
                end
              end
            end
            PH_FLUSH: begin
              load = 1'b1;
              if (st_bsy) begin
                burst.kind = BK_POLL;
              end else if (sectors_r == 32'd0) begin
                phase_nxt  = PH_IDLE;
                burst.kind = BK_DONE;
              end else begin
                chunk_nxt   = chunk_size;
                word_nxt    = '0;
                retries_nxt = cfg.retry_limit;
                phase_nxt   = PH_POLL;
                burst.kind  = BK_CHUNK;
              end
            end
            PH_GAP: begin
              // The status value does not matter between read chunks.
              load        = 1'b1;
              chunk_nxt   = chunk_size;
              word_nxt    = '0;
              retries_nxt = cfg.retry_limit;
              phase_nxt   = PH_POLL;
              burst.kind  = BK_CHUNK;
            end
            default: begin
              load = 1'b0;
            end
          endcase
        end
        REQ_DATA: begin
          if (phase_r == PH_DATA) begin
            load = 1'b1;
            if (!word_wrap) begin
              word_nxt   = word_inc;
              burst.kind = BK_WORD;
            end else begin
              word_nxt    = '0;
              lba_nxt     = lba_r + 1'b1;
              sectors_nxt = sectors_dec;
              chunk_nxt   = chunk_dec;
              if (chunk_dec != 8'd0) begin
                retries_nxt = cfg.retry_limit;
                phase_nxt   = PH_POLL;
                burst.kind  = BK_WORDPOLL;
              end else if (writing_r) begin
                phase_nxt  = PH_FLUSH;
                burst.kind = BK_WORDFLUSH;
              end else if (sectors_dec == 32'd0) begin
                phase_nxt  = PH_IDLE;
                burst.kind = BK_WORDDONE;
              end else begin
                phase_nxt  = PH_GAP;
                burst.kind = BK_WORDPOLL;
              end
            end
          end
        end
        default: begin
          load = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      writing_r <= 1'b0;
      sectors_r <= '0;
      lba_r     <= '0;
      chunk_r   <= '0;
      word_r    <= '0;
      retries_r <= '0;
    end else begin
      phase_r   <= phase_nxt;
      writing_r <= writing_nxt;
      sectors_r <= sectors_nxt;
      lba_r     <= lba_nxt;
      chunk_r   <= chunk_nxt;
      word_r    <= word_nxt;
      retries_r <= retries_nxt;
    end
  end

endmodule

[hw/rtl/ata_seq_emit.sv]
// ----------------------------------------------------------------------------
// ATA PIO sequencer result emitter
// Holds one result burst and plays it out one result per transfer.
// ----------------------------------------------------------------------------
module ata_seq_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  ata_seq_pkg::burst_t  burst,
  input  logic                 out_ready,
  output logic                 out_valid,
  output ata_seq_pkg::result_t res,
  output logic                 free
);
  import ata_seq_pkg::*;

  burst_t     burst_r;
  logic       valid_r, valid_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic [2:0] last_idx;
  logic       at_last;

  always_comb begin
    unique case (burst_r.kind)
      BK_CHUNK:     last_idx = 3'd6;
      BK_WAITPOLL:  last_idx = 3'd1;
      BK_WORDPOLL:  last_idx = 3'd1;
      BK_WORDFLUSH: last_idx = 3'd2;
      BK_WORDDONE:  last_idx = 3'd1;
      default:      last_idx = 3'd0;
    endcase
  end

  assign at_last   = (idx_r == last_idx);
  assign free      = ~valid_r | (out_ready & at_last);
  assign out_valid = valid_r;

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = '0;
    end else if (valid_r && out_ready) begin
      if (at_last) begin
        valid_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      burst_r <= burst;
    end
  end

  always_comb begin
    res           = '0;
    res.last      = at_last;
    unique case (burst_r.kind)
      BK_DONE: begin
        res.action  = ACT_DONE;
        res.success = burst_r.ok;
      end
      BK_DPHASE: begin
        res.action = ACT_DPHASE;
      end
      BK_POLL: begin
        res.action = ACT_POLL;
      end
      BK_WAITPOLL: begin
        if (idx_r == 3'd0) begin
          res.action  = ACT_WAIT;
          res.wait_ms = burst_r.wait_ms;
        end else begin
          res.action = ACT_POLL;
        end
      end
      BK_CHUNK: begin
        res.action = ACT_REG_WRITE;
        unique case (idx_r)
          3'd0: begin
            res.reg_index = TF_DRVHEAD;
            res.reg_value = {DRVHEAD_BASE, burst_r.lba[27:24]};
          end
          3'd1: begin
            res.reg_index = TF_COUNT;
            res.reg_value = burst_r.count;
          end
          3'd2: begin
            res.reg_index = TF_LBA_LO;
            res.reg_value = burst_r.lba[7:0];
          end
          3'd3: begin
            res.reg_index = TF_LBA_MID;
            res.reg_value = burst_r.lba[15:8];
          end
          3'd4: begin
            res.reg_index = TF_LBA_HI;
            res.reg_value = burst_r.lba[23:16];
          end
          3'd5: begin
            res.reg_index = TF_COMMAND;
            res.reg_value = burst_r.writing ? CMD_WRITE : CMD_READ;
          end
          default: begin
            res.action = ACT_POLL;
          end
        endcase
      end
      BK_WORD, BK_WORDPOLL, BK_WORDFLUSH, BK_WORDDONE: begin
        if (idx_r == 3'd0) begin
          res.action   = burst_r.writing ? ACT_TO_DRIVE : ACT_TO_HOST;
          res.data_out = burst_r.data;
        end else if (burst_r.kind == BK_WORDDONE) begin
          res.action  = ACT_DONE;
          res.success = 1'b1;
        end else if (burst_r.kind == BK_WORDFLUSH && idx_r == 3'd1) begin
          res.action    = ACT_REG_WRITE;
          res.reg_index = TF_COMMAND;
          res.reg_value = CMD_FLUSH;
        end else begin
          res.action = ACT_POLL;
        end
      end
      default: begin
        res.action = ACT_POLL;
      end
    endcase
  end

endmodule

[hw/rtl/ata_pio_transfer_sequencer_top.sv]
// ----------------------------------------------------------------------------
// ATA PIO LBA28 transfer sequencer
// Host-side sequencer that turns start, status and data transfers into
// task-file writes, status polls, data-phase requests and forwarded words.
// ----------------------------------------------------------------------------
// The first result of an item appears in the cycle after its transfer.
// Throughput: one item per cycle while each item causes at most one result
// and out_tready stays high; an item causing n results (n up to 7, for a new
// chunk) holds the input until the single result register hands over its last.
// Reset: rst_n is synchronous, active low; it empties the result register,
// sends the sequencer idle and loads the configuration reset values.
module ata_pio_transfer_sequencer_top (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata from bit 0: write_op[0], start_lba[32:1], sector_total[64:33],
  // status_byte[72:65], data_in[88:73], zero fill [95:89].
  input  logic [95:0] in_tdata,
  // tuser from bit 0: req_type[1:0].
  input  logic [1:0]  in_tuser,
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata from bit 0: reg_index[2:0], reg_value[10:3], data_out[26:11],
  // wait_ms[42:27], success[43], zero fill [47:44].
  output logic [47:0] out_tdata,
  // tuser from bit 0: action[2:0].
  output logic [2:0]  out_tuser,
  output logic        out_tlast,
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ata_seq_pkg::*;

  cfg_t    cfg;
  burst_t  burst;
  result_t res;
  logic    accept;
  logic    load;
  logic    emit_free;

  // The register file never stalls the bus.
  assign cfg_pready = 1'b1;

  ata_seq_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // A new item is taken whenever the emitter is empty or hands over its
  // final result in this same cycle, so single-result items stream at the
  // full clock rate while the previous result still sits in the register.
  assign in_tready = emit_free;
  assign accept    = in_tvalid & in_tready;

  // The core updates the transfer state at the transfer edge and captures
  // everything the results need in a burst descriptor, so later items can
  // change the state while the burst is still being played out.
  ata_seq_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .req_type     (in_tuser),
    .write_op     (in_tdata[0]),
    .start_lba    (in_tdata[32:1]),
    .sector_total (in_tdata[64:33]),
    .status_byte  (in_tdata[72:65]),
    .data_in      (in_tdata[88:73]),
    .cfg          (cfg),
    .load         (load),
    .burst        (burst)
  );

  // Items that cause no result, such as a stray status or data transfer,
  // never load the emitter.
  ata_seq_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .burst     (burst),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .res       (res),
    .free      (emit_free)
  );

  assign out_tdata = {4'b0000, res.success, res.wait_ms, res.data_out,
                      res.reg_value, res.reg_index};
  assign out_tuser = res.action;
  assign out_tlast = res.last;

endmodule

[hw/rtl/ata_seq_checker.sv]
// ----------------------------------------------------------------------------
// ATA PIO sequencer port checker
// Watches the stream ports of the sequencer over time.
// ----------------------------------------------------------------------------
`include "ata_pio_transfer_sequencer_top_macros.svh"

module ata_seq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);
  import ata_seq_pkg::*;

  // A stalled result keeps its contents.
  `ATA_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result changed")

  // Reset empties the result register.
  `ATA_ASSERT_RST(a_rst_empty, !rst_n |=> !out_tvalid, "result valid after reset")

  // The input only stalls behind a pending result burst.
  `ATA_ASSERT(a_stall_cause, !in_tready |-> out_tvalid && !(out_tready && out_tlast), "input stalled without pending burst")

  // Done and data-phase results always close their burst; a wait never does.
  `ATA_ASSERT(a_done_last, out_tvalid && (out_tuser == ACT_DONE || out_tuser == ACT_DPHASE) |-> out_tlast, "done or data phase not last")
  `ATA_ASSERT(a_wait_not_last, out_tvalid && out_tuser == ACT_WAIT |-> !out_tlast, "wait result ended a burst")

endmodule

bind ata_pio_transfer_sequencer_top ata_seq_checker u_ata_seq_checker (.*);

[sim/ata_pio_transfer_sequencer_top_tb.sv]
// ----------------------------------------------------------------------------
// ATA PIO transfer sequencer testbench
// Drives start, status and data transfers into the sequencer and checks every
// task-file write, poll, wait, data-phase, forwarded word and done result
// against an in-bench model of the LBA28 chunking, status judging and retry
// counting. Both stream sides idle at random, and the limit registers are
// reprogrammed between phases through the APB port.
// ----------------------------------------------------------------------------
module ata_pio_transfer_sequencer_top_tb;
  import ata_seq_pkg::*;

  // Request type the block must drop without any result.
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // Cycles without any transfer before the run is declared hung.
  localparam int QUIET_LIMIT = 2000;
  // Mismatch lines printed before the rest are only counted.
  localparam int SHOW_ERRORS = 25;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;
  logic [1:0]  in_tuser = REQ_START;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  ata_pio_transfer_sequencer_top DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Sequencer model state. It mirrors the block's job registers and the two
  // limit registers, and is advanced once per accepted input transfer.
  // --------------------------------------------------------------------------
  phase_t             seq_phase = PH_IDLE;
  logic               seq_writing = 1'b0;
  logic [31:0]        seq_sectors = '0;
  logic [LBA_W-1:0]   seq_lba = '0;
  logic [7:0]         seq_chunk = '0;
  logic [8:0]         seq_word = '0;
  logic [RETRY_W-1:0] seq_retries = '0;
  logic [RETRY_W-1:0] retry_limit_q = RETRY_LIMIT_RST;
  logic [WAIT_W-1:0]  spinup_wait_q = SPINUP_WAIT_RST;

  // Bus actions the block still owes, oldest first.
  result_t pending_actions[$];
  int      n_emitted;

  // Stimulus knobs and run statistics.
  bit idle_on = 1'b1;
  bit stall_on = 1'b1;
  int n_in = 0;
  int n_ctl = 0;
  int n_out = 0;
  int n_cfg = 0;
  int n_ok = 0;
  int n_failed_jobs = 0;
  int n_errors = 0;
  int rdy_hold = 0;
  int stall_roll;
  int quiet_cycles = 0;

  function automatic void expect_action(logic [2:0] act, logic [2:0] idx = '0,
                                        logic [7:0] val = '0, logic [15:0] dat = '0,
                                        logic [15:0] wt = '0, logic ok = 1'b0);
    result_t r;
    r.action    = act;
    r.reg_index = idx;
    r.reg_value = val;
    r.data_out  = dat;
    r.wait_ms   = wt;
    r.success   = ok;
    r.last      = 1'b0;
    pending_actions.push_back(r);
    n_emitted++;
  endfunction

  function automatic void end_job(logic ok);
    expect_action(ACT_DONE, '0, '0, '0, '0, ok);
    seq_phase = PH_IDLE;
  endfunction

  // Task-file writes for the next chunk of at most CHUNK_SECTORS sectors.
  function automatic void open_chunk();
    logic [31:0]      cnt;
    logic [LBA_W-1:0] a;
    cnt = (seq_sectors < CHUNK_SECTORS) ? seq_sectors : 32'(CHUNK_SECTORS);
    a = seq_lba;
    seq_chunk = cnt[7:0];
    seq_word = '0;
    seq_retries = retry_limit_q;
    expect_action(ACT_REG_WRITE, TF_DRVHEAD, {DRVHEAD_BASE, a[27:24]});
    expect_action(ACT_REG_WRITE, TF_COUNT, cnt[7:0]);
    expect_action(ACT_REG_WRITE, TF_LBA_LO, a[7:0]);
    expect_action(ACT_REG_WRITE, TF_LBA_MID, a[15:8]);
    expect_action(ACT_REG_WRITE, TF_LBA_HI, a[23:16]);
    expect_action(ACT_REG_WRITE, TF_COMMAND, seq_writing ? CMD_WRITE : CMD_READ);
    expect_action(ACT_POLL);
    seq_phase = PH_POLL;
  endfunction

  // Status byte seen while polling for a data phase.
  function automatic void judge_status(logic [7:0] st);
    logic go;
    logic spin;
    go = 1'b0;
    spin = 1'b0;
    if (seq_retries == 0) begin
      end_job(1'b0);
      return;
    end
    if (seq_writing && st[ST_DRQ]) go = 1'b1;
    else if (st[ST_BSY]) go = 1'b0;
    else if (!st[ST_RDY]) spin = 1'b1;
    else if (st[ST_DRQ]) go = 1'b1;
    if (go) begin
      seq_word = '0;
      seq_phase = PH_DATA;
      expect_action(ACT_DPHASE);
      return;
    end
    seq_retries = seq_retries - 1'b1;
    if (seq_retries == 0) begin
      end_job(1'b0);
      return;
    end
    if (spin) expect_action(ACT_WAIT, '0, '0, '0, spinup_wait_q);
    expect_action(ACT_POLL);
  endfunction

  // One data word of the open data phase; sector and chunk ends follow it.
  function automatic void take_word(logic [15:0] w);
    expect_action(seq_writing ? ACT_TO_DRIVE : ACT_TO_HOST, '0, '0, w);
    seq_word = seq_word + 1'b1;
    if (seq_word < WORDS_PER_SECTOR) return;
    seq_word = '0;
    seq_lba = seq_lba + 1'b1;
    seq_sectors = seq_sectors - 1'b1;
    seq_chunk = seq_chunk - 1'b1;
    if (seq_chunk != 0) begin
      seq_retries = retry_limit_q;
      seq_phase = PH_POLL;
      expect_action(ACT_POLL);
    end else if (seq_writing) begin
      seq_phase = PH_FLUSH;
      expect_action(ACT_REG_WRITE, TF_COMMAND, CMD_FLUSH);
      expect_action(ACT_POLL);
    end else if (seq_sectors == 0) begin
      end_job(1'b1);
    end else begin
      seq_phase = PH_GAP;
      expect_action(ACT_POLL);
    end
  endfunction

  function automatic void advance_sequencer(logic [1:0] req, logic wop, logic [31:0] lba,
                                            logic [31:0] total, logic [7:0] st,
                                            logic [15:0] w);
    n_emitted = 0;
    case (req)
      REQ_START: begin
        // A start always replaces whatever job was running.
        seq_writing = wop;
        seq_lba = lba[LBA_W-1:0];
        seq_sectors = total;
        seq_chunk = '0;
        seq_word = '0;
        seq_retries = '0;
        if (total == 0) end_job(1'b1);
        else open_chunk();
      end
      REQ_STATUS: begin
        case (seq_phase)
          PH_POLL: judge_status(st);
          PH_FLUSH: begin
            if (st[ST_BSY]) expect_action(ACT_POLL);
            else if (seq_sectors == 0) end_job(1'b1);
            else open_chunk();
          end
          PH_GAP: open_chunk();
          default: ;
        endcase
      end
      REQ_DATA: begin
        if (seq_phase == PH_DATA) take_word(w);
      end
      default: ;
    endcase
    if (n_emitted > 0) pending_actions[pending_actions.size()-1].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Input side. An item is held on the bus until the block takes it, and the
  // model is advanced at that same edge.
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(logic [1:0] req, logic wop, logic [31:0] lba, logic [31:0] total,
                           logic [7:0] st, logic [15:0] w);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {7'd0, w, st, total, lba, wop};
    do @(posedge clk); while (!in_tready);
    n_in++;
    if (req == REQ_START || req == REQ_STATUS) n_ctl++;
    advance_sequencer(req, wop, lba, total, st, w);
  endtask

  // Fields that the request type does not use carry random values throughout.
  task automatic send_start(logic wop, logic [31:0] lba, logic [31:0] total);
    send_item(REQ_START, wop, lba, total, 8'($urandom), 16'($urandom));
  endtask

  task automatic send_status(logic [7:0] st);
    send_item(REQ_STATUS, 1'($urandom), $urandom, $urandom, st, 16'($urandom));
  endtask

  task automatic send_word(logic [15:0] w);
    send_item(REQ_DATA, 1'($urandom), $urandom, $urandom, 8'($urandom), w);
  endtask

  // A transfer the block must ignore in its present phase.
  task automatic send_noise();
    logic [1:0] req;
    if ($urandom_range(0, 2) == 0) req = REQ_UNUSED;
    else if (seq_phase == PH_DATA) req = REQ_STATUS;
    else if (seq_phase == PH_IDLE) req = $urandom_range(0, 1) ? REQ_STATUS : REQ_DATA;
    else req = REQ_DATA;
    send_item(req, 1'($urandom), $urandom, $urandom, 8'($urandom), 16'($urandom));
  endtask

  // Drops valid and waits for every owed result, then lets the block settle.
  task automatic wait_drained(int settle);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_actions.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // Writes both limit registers as two back-to-back APB writes, block idle.
  task automatic program_limits(logic [31:0] retry, logic [31:0] spin);
    logic idx;
    wait_drained(12);
    for (int i = 0; i < 2; i++) begin
      idx = (i == 0) ? CFG_RETRY_LIMIT : CFG_SPINUP_WAIT;
      cfg_psel <= 1'b1;
      cfg_pwrite <= 1'b1;
      cfg_penable <= 1'b0;
      cfg_paddr <= {idx, 2'b00};
      cfg_pwdata <= (i == 0) ? retry : spin;
      @(posedge clk);
      cfg_penable <= 1'b1;
      do @(posedge clk); while (!cfg_pready);
      if (idx == CFG_RETRY_LIMIT) retry_limit_q = retry[RETRY_W-1:0];
      else spinup_wait_q = spin[WAIT_W-1:0];
      n_cfg++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // Status byte for a poll, leaning toward a drive that becomes ready.
  function automatic logic [7:0] pick_poll_status();
    int         roll;
    logic [7:0] raw;
    roll = $urandom_range(0, 99);
    raw = 8'($urandom);
    if (roll < 45) return seq_writing ? (raw | 8'h08) : ((raw & 8'h37) | 8'h48);
    if (roll < 65) return seq_writing ? ((raw | 8'h80) & 8'hF7) : (raw | 8'h80);
    if (roll < 80) return raw & (seq_writing ? 8'h37 : 8'h3F);
    return raw;
  endfunction

  // Starts a job and answers whatever the model says the block waits for,
  // until the job ends or the step budget runs out.
  task automatic run_job(logic wop, logic [31:0] lba, logic [31:0] total, int max_steps,
                         bit noisy);
    int steps;
    steps = 0;
    send_start(wop, lba, total);
    while (seq_phase != PH_IDLE && steps < max_steps) begin
      steps++;
      if (noisy && $urandom_range(0, 99) < 5) begin
        send_noise();
      end else begin
        case (seq_phase)
          PH_POLL: send_status(pick_poll_status());
          PH_DATA: send_word(16'($urandom));
          PH_FLUSH: send_status($urandom_range(0, 1) ? (8'($urandom) | 8'h80)
                                                     : (8'($urandom) & 8'h7F));
          default: send_status(8'($urandom));
        endcase
      end
      if (noisy && $urandom_range(0, 99) < 3) wait_drained(0);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Field extremes and every status case, with the limits left at reset.
  task automatic test_directed_cases();
    send_start(1'b0, 32'h0000_0000, 32'd0);        // empty job finishes at once
    send_start(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // LBA cut to 28 bits
    send_status(8'h80);                            // busy
    send_status(8'h00);                            // not ready: spin-up wait
    send_status(8'h41);                            // ready with the error bit, no DRQ
    send_status(8'h60);                            // device fault
    send_status(8'hC8);                            // busy wins over DRQ on a read
    send_status(8'h48);                            // data phase opens
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_status(8'hFF);                            // status during data: dropped
    send_item(REQ_UNUSED, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
    send_start(1'b1, 32'h0ABC_DEF1, 32'd300);      // replaces the running job
    send_word(16'h1234);                           // data while polling: dropped
    send_status(8'h88);                            // write with DRQ ignores busy
    send_word(16'($urandom));
    send_start(1'b1, 32'h0000_0000, 32'd1);
    send_status(8'h08);                            // write with DRQ, not ready
    send_word(16'h8001);
    wait_drained(0);
  endtask

  // Transfers that fail once the poll budget is spent.
  task automatic test_retry_exhaustion();
    program_limits(32'd1, 32'd0);
    send_start(1'b0, $urandom, 32'd5);
    send_status(8'h80);                            // single poll allowed: fails
    send_status(8'h48);                            // block is idle again: dropped
    program_limits(32'd2, 32'd65535);
    send_start(1'b1, $urandom, 32'd3);
    send_status(8'h00);                            // longest spin-up wait
    send_status(8'h41);
    program_limits(32'd0, 32'd1);
    send_start(1'b0, $urandom, 32'd1);
    send_status(8'h48);                            // no polls at all: fails at once
  endtask

  // One whole sector written to disk: the sector end, the cache flush and
  // the flush polls up to the done result.
  task automatic test_sector_end();
    program_limits(32'd20, $urandom_range(0, 65535));
    run_job(1'b1, $urandom, 32'd1, 600, 1'b0);
  endtask

  // Short random jobs, most of them dropped before their data phase ends,
  // under four limit settings.
  task automatic test_random_jobs();
    int          ctl_mark;
    int          roll;
    int          budget;
    logic [31:0] total;
    for (int pass = 0; pass < 4; pass++) begin
      case (pass)
        0: program_limits(32'd1, 32'd65535);
        1: program_limits($urandom_range(2, 8), 32'd0);
        2: program_limits($urandom_range(3, 12), $urandom_range(0, 65535));
        default: program_limits($urandom_range(4, 30), $urandom_range(0, 65535));
      endcase
      ctl_mark = n_ctl;
      while (n_ctl - ctl_mark < 6) begin
        roll = $urandom_range(0, 99);
        if (roll < 10) total = 32'd0;
        else if (roll < 65) total = 32'd1;
        else if (roll < 85) total = 32'd2;
        else total = $urandom;
        budget = $urandom_range(1, 12);
        // Now and then a job runs with neither side idling.
        idle_on = ($urandom_range(0, 9) != 0);
        stall_on = idle_on;
        run_job(1'($urandom), $urandom, total, budget, 1'b1);
      end
      idle_on = 1'b1;
      stall_on = 1'b1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random back-pressure, mostly short holds with a few long
  // stalls, and a check of every result against the oldest owed action.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!stall_on) begin
      out_tready <= 1'b1;
      rdy_hold <= 0;
    end else if (rdy_hold > 0) begin
      rdy_hold <= rdy_hold - 1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 65) begin
        out_tready <= 1'b1;
        rdy_hold <= $urandom_range(0, 7);
      end else if (stall_roll < 95) begin
        out_tready <= 1'b0;
        rdy_hold <= $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b0;
        rdy_hold <= $urandom_range(9, 39);
      end
    end
  end

  function automatic string describe(result_t r);
    return $sformatf("{act %0d reg %0d val 0x%02h data 0x%04h wait %0d ok %0b last %0b}",
                     r.action, r.reg_index, r.reg_value, r.data_out, r.wait_ms,
                     r.success, r.last);
  endfunction

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.action    = out_tuser;
      got.reg_index = out_tdata[2:0];
      got.reg_value = out_tdata[10:3];
      got.data_out  = out_tdata[26:11];
      got.wait_ms   = out_tdata[42:27];
      got.success   = out_tdata[43];
      got.last      = out_tlast;
      n_out++;
      if (got.action == ACT_DONE) begin
        if (got.success) n_ok++;
        else n_failed_jobs++;
      end
      if (pending_actions.size() == 0) begin
        n_errors++;
        if (n_errors <= SHOW_ERRORS)
          $display("%0t: unexpected result, expected none, got %s", $time, describe(got));
      end else begin
        want = pending_actions.pop_front();
        if (got !== want) begin
          n_errors++;
          if (n_errors <= SHOW_ERRORS)
            $display("%0t: result mismatch, expected %s, got %s", $time, describe(want),
                     describe(got));
        end
      end
    end
  end

  // Hang detection: any stretch this long without a single transfer on any
  // port means the block stopped answering.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout after %0d idle cycles, %0d results still owed", quiet_cycles,
               pending_actions.size());
      $display("ata_pio_transfer_sequencer_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_retry_exhaustion();
    test_sector_end();
    test_random_jobs();
    wait_drained(20);
    $display("Covered %0d input transfers (%0d starts and status reads), %0d results,",
             n_in, n_ctl, n_out);
    $display("%0d limit writes; jobs ended %0d complete and %0d on spent retries.",
             n_cfg, n_ok, n_failed_jobs);
    if (n_errors == 0) begin
      $display("ata_pio_transfer_sequencer_top test passed");
    end else begin
      $display("%0d result errors.", n_errors);
      $display("ata_pio_transfer_sequencer_top test failed");
    end
    $finish;
  end

endmodule
